FILE: hw/rtl/plane_point_projection_macros.svh
// Assertion macros for the plane point projection block.
`ifndef PLANE_POINT_PROJECTION_MACROS_SVH
`define PLANE_POINT_PROJECTION_MACROS_SVH

// Same-cycle implication, off during reset.
`define PPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define PPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ppp_pkg.sv
// Shared constants, types and helpers of the plane point projection block.
`default_nettype none

package ppp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int CFG_IDX_W = 2;

    // search accumulators, numerator widths
    localparam int ACC_W = 6 * CW + 4;
    localparam int NU_W  = 3 * CW + 2;
    localparam int NV_W  = 2 * CW + 2;

    localparam logic [CW-1:0] NZ_RESET = CW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] HALF     = {1'b1, {(CW - 1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PC_NYNY,
        PC_NZNZ,
        PC_NXNX,
        PC_NXNY,
        PC_NXNZ,
        PC_QLNL,
        PC_QLNH,
        PC_QHNL,
        PC_QHNH,
        PC_LAST,
        PC_IDLE
    } pc_state_t;

    typedef struct packed {
        logic [2*CW-1:0] q;
        logic [4*CW-1:0] den_u;
        logic [2*CW-1:0] c2_mag;
        logic [2*CW-1:0] c3_mag;
        logic            c2_neg;
        logic            c3_neg;
        logic [CW-1:0]   ny_mag;
        logic [CW-1:0]   nz_mag;
        logic            ny_neg;
        logic            nz_neg;
        logic            deg;
    } coef_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] ws;
        logic signed [ACC_W-1:0] s;
        logic [CW-1:0]           m;
        logic                    neg;
    } lane_t;

    typedef struct packed {
        lane_t u;
        lane_t v;
    } srch_t;

    function automatic logic [CW-1:0] mag(input logic [CW-1:0] x);
        return x[CW-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ppp_cfg_if.sv
// Register write channel.
`default_nettype none

interface ppp_cfg_if;
    import ppp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CW-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ppp_point_if.sv
// Point request channel.
`default_nettype none

interface ppp_point_if;
    import ppp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ppp_coord_if.sv
// Plane coordinate result channel.
`default_nettype none

interface ppp_coord_if;
    import ppp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] coord_u;
    logic signed [CW-1:0] coord_v;
    logic                 degenerate;
    logic                 saturated;

    modport source (output valid, output coord_u, output coord_v, output degenerate,
                    output saturated, input ready);
    modport sink (input valid, input coord_u, input coord_v, input degenerate,
                  input saturated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/plane_point_projection.sv
// Plane point projection top level: 3D Q16.16 point to rounded, saturated plane coordinates.
// Pipeline: five front stages, one stage per result bit, then the output register.
// Throughput is one point per cycle; the whole pipeline holds only while the last search
// stage is full and the output register is blocked.
// After reset and after each normal register write, a coefficient pass runs on one
// shared multiplier and holds ready low. Reset sets the normal to (0, 0, 1.0).
`default_nettype none
`include "plane_point_projection_macros.svh"

module plane_point_projection (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ppp_cfg_if.sink       cfg,
    ppp_point_if.sink     point_in,
    ppp_coord_if.source   coord_out
);
    import ppp_pkg::*;

    coef_t coef;
    logic  busy;
    logic  adv, take, out_load;
    srch_t st [0:CW];
    logic  sv [0:CW];

    logic                 out_valid_reg;
    logic signed [CW-1:0] coord_u_reg, coord_v_reg;
    logic                 deg_reg, sat_reg;
    logic [CW:0]          cu, cv;

    ppp_precomp u_precomp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coef  (coef),
        .busy  (busy)
    );

    assign out_load       = !out_valid_reg || coord_out.ready;
    assign adv            = !sv[CW] || out_load;
    assign point_in.ready = adv && !busy;
    assign take           = point_in.valid && point_in.ready;

    ppp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .take  (take),
        .px    (point_in.point_x),
        .py    (point_in.point_y),
        .pz    (point_in.point_z),
        .coef  (coef),
        .v_out (sv[0]),
        .init  (st[0])
    );

    for (genvar k = 0; k < CW; k++)
    begin : g_step
        logic signed [ACC_W-1:0] d_u, d_v;

        // den scaled to the weight of this stage's bit
        assign d_u = signed'(ACC_W'(coef.den_u) << (2*CW - 2*k));
        assign d_v = signed'(ACC_W'(coef.q) << (2*CW - 2*k));

        ppp_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .v_in  (sv[k]),
            .d_in  (st[k]),
            .d_u   (d_u),
            .d_v   (d_v),
            .v_out (sv[k+1]),
            .d_out (st[k+1])
        );
    end

    // clip the magnitude to the signed range, then apply the sign
    function automatic logic [CW:0] clip(input lane_t x);
        logic          over;
        logic [CW-1:0] mm;
        over = x.neg ? (x.m > HALF) : (x.m > (HALF - 1'b1));
        mm   = over ? (x.neg ? HALF : (HALF - 1'b1)) : x.m;
        return {over, (x.neg ? (~mm + 1'b1) : mm)};
    endfunction

    assign cu = clip(st[CW].u);
    assign cv = clip(st[CW].v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= sv[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && sv[CW])
        begin
            if (coef.deg)
            begin
                coord_u_reg <= '0;
                coord_v_reg <= '0;
                deg_reg     <= 1'b1;
                sat_reg     <= 1'b0;
            end
            else
            begin
                coord_u_reg <= signed'(cu[CW-1:0]);
                coord_v_reg <= signed'(cv[CW-1:0]);
                deg_reg     <= 1'b0;
                sat_reg     <= cu[CW] || cv[CW];
            end
        end
    end

    assign coord_out.valid      = out_valid_reg;
    assign coord_out.coord_u    = coord_u_reg;
    assign coord_out.coord_v    = coord_v_reg;
    assign coord_out.degenerate = deg_reg;
    assign coord_out.saturated  = sat_reg;

    `PPP_ASSERT_IMP(a_busy_holds_input, clk, rst_n, busy, !point_in.ready, "request taken during coefficient pass")
    `PPP_ASSERT_NXT(a_write_restarts, clk, rst_n, cfg.valid && cfg.ready && (cfg.index == REG_NORMAL_X || cfg.index == REG_NORMAL_Y || cfg.index == REG_NORMAL_Z), busy, "register write did not restart coefficient pass")
    `PPP_ASSERT_IMP(a_degenerate_zero, clk, rst_n, coord_out.valid && coord_out.degenerate, coord_out.coord_u == '0 && coord_out.coord_v == '0 && !coord_out.saturated, "degenerate result not zero")

endmodule

`default_nettype wire

FILE: hw/rtl/ppp_precomp.sv
// Normal registers and the sequential pass that derives the plane coefficients.
`default_nettype none

module ppp_precomp (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ppp_cfg_if.sink     cfg,
    output ppp_pkg::coef_t coef,
    output logic        busy
);
    import ppp_pkg::*;

    logic [CW-1:0]   nx_reg, ny_reg, nz_reg;
    pc_state_t       state_reg, state_next;
    logic [2*CW-1:0] prod_reg;
    logic [2*CW-1:0] q_reg, nn_reg, c2_reg, c3_reg;
    logic [4*CW-1:0] den_reg;
    logic [CW-1:0]   mul_a, mul_b;
    logic [CW-1:0]   nxm, nym, nzm;
    logic            hit;

    assign cfg.ready = 1'b1;
    assign hit = cfg.valid && (cfg.index == REG_NORMAL_X || cfg.index == REG_NORMAL_Y ||
                               cfg.index == REG_NORMAL_Z);

    assign nxm = mag(nx_reg);
    assign nym = mag(ny_reg);
    assign nzm = mag(nz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= NZ_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NORMAL_X: nx_reg <= cfg.data;
                REG_NORMAL_Y: ny_reg <= cfg.data;
                REG_NORMAL_Z: nz_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // restart the pass on every normal register write
    always_comb
    begin
        if (hit)
        begin
            state_next = PC_NYNY;
        end
        else
        begin
            unique case (state_reg)
                PC_NYNY: state_next = PC_NZNZ;
                PC_NZNZ: state_next = PC_NXNX;
                PC_NXNX: state_next = PC_NXNY;
                PC_NXNY: state_next = PC_NXNZ;
                PC_NXNZ: state_next = PC_QLNL;
                PC_QLNL: state_next = PC_QLNH;
                PC_QLNH: state_next = PC_QHNL;
                PC_QHNL: state_next = PC_QHNH;
                PC_QHNH: state_next = PC_LAST;
                PC_LAST: state_next = PC_IDLE;
                PC_IDLE: state_next = PC_IDLE;
                default: state_next = PC_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PC_NYNY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // multiplier operands issued in each step
    always_comb
    begin
        unique case (state_reg)
            PC_NYNY: begin mul_a = nym; mul_b = nym; end
            PC_NZNZ: begin mul_a = nzm; mul_b = nzm; end
            PC_NXNX: begin mul_a = nxm; mul_b = nxm; end
            PC_NXNY: begin mul_a = nxm; mul_b = nym; end
            PC_NXNZ: begin mul_a = nxm; mul_b = nzm; end
            PC_QLNL: begin mul_a = q_reg[CW-1:0];  mul_b = nn_reg[CW-1:0];  end
            PC_QLNH: begin mul_a = q_reg[CW-1:0];  mul_b = nn_reg[2*CW-1:CW]; end
            PC_QHNL: begin mul_a = q_reg[2*CW-1:CW]; mul_b = nn_reg[CW-1:0];  end
            PC_QHNH: begin mul_a = q_reg[2*CW-1:CW]; mul_b = nn_reg[2*CW-1:CW]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // each step consumes the product issued in the previous step
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            PC_NZNZ: q_reg   <= prod_reg;
            PC_NXNX: q_reg   <= q_reg + prod_reg;
            PC_NXNY: nn_reg  <= q_reg + prod_reg;
            PC_NXNZ: c2_reg  <= prod_reg;
            PC_QLNL: c3_reg  <= prod_reg;
            PC_QLNH: den_reg <= (4*CW)'(prod_reg);
            PC_QHNL: den_reg <= den_reg + ((4*CW)'(prod_reg) << CW);
            PC_QHNH: den_reg <= den_reg + ((4*CW)'(prod_reg) << CW);
            PC_LAST: den_reg <= den_reg + ((4*CW)'(prod_reg) << (2*CW));
            default: ;
        endcase
    end

    assign busy = (state_reg != PC_IDLE);

    always_comb
    begin
        coef.q      = q_reg;
        coef.den_u  = den_reg;
        coef.c2_mag = c2_reg;
        coef.c3_mag = c3_reg;
        coef.c2_neg = nx_reg[CW-1] ^ ny_reg[CW-1];
        coef.c3_neg = nx_reg[CW-1] ^ nz_reg[CW-1];
        coef.ny_mag = nym;
        coef.nz_mag = nzm;
        coef.ny_neg = ny_reg[CW-1];
        coef.nz_neg = nz_reg[CW-1];
        coef.deg    = (q_reg == '0);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ppp_front.sv
// Front pipeline: numerators, their magnitudes and exact squares, five stages.
`default_nettype none

module ppp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 take,
    input  wire logic [ppp_pkg::CW-1:0] px,
    input  wire logic [ppp_pkg::CW-1:0] py,
    input  wire logic [ppp_pkg::CW-1:0] pz,
    input  ppp_pkg::coef_t            coef,
    output logic                      v_out,
    output ppp_pkg::srch_t            init
);
    import ppp_pkg::*;

    logic [4:0] fv_reg;

    // stage 1: limb products
    logic [2*CW-1:0] u0h_reg, u0l_reg, u1h_reg, u1l_reg, u2h_reg, u2l_reg, v1_reg, v2_reg;
    logic            s0_reg, s1_reg, s2_reg, sv1_reg, sv2_reg;
    // stage 2: signed numerators
    logic signed [NU_W-1:0] numu_reg, numu_next;
    logic signed [NV_W-1:0] numv_reg, numv_next;
    // stage 3: magnitudes
    logic [3*CW-1:0] umag_reg;
    logic [2*CW-1:0] vmag_reg;
    logic            nu3_reg, nv3_reg;
    // stage 4: square partials
    logic [2*CW-1:0] pa00_reg, pa01_reg, pa02_reg, pa11_reg, pa12_reg, pa22_reg;
    logic [2*CW-1:0] pb00_reg, pb01_reg, pb11_reg;
    logic            nu4_reg, nv4_reg;
    // stage 5: four times the squared numerators
    logic signed [ACC_W-1:0] su_reg, su_next, sq_reg, sq_next;
    logic            nu5_reg, nv5_reg;

    logic [CW-1:0] pxm, pym, pzm;
    logic signed [NU_W-1:0] t0, t1, t2;
    logic signed [NV_W-1:0] w1, w2;

    assign pxm = mag(px);
    assign pym = mag(py);
    assign pzm = mag(pz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (adv)
        begin
            fv_reg <= {fv_reg[3:0], take};
        end
    end

    always_comb
    begin
        t0 = signed'(NU_W'({u0h_reg, {CW{1'b0}}} + (3*CW)'(u0l_reg)));
        t1 = signed'(NU_W'({u1h_reg, {CW{1'b0}}} + (3*CW)'(u1l_reg)));
        t2 = signed'(NU_W'({u2h_reg, {CW{1'b0}}} + (3*CW)'(u2l_reg)));
        w1 = signed'(NV_W'(v1_reg));
        w2 = signed'(NV_W'(v2_reg));
        numu_next = (s0_reg ? -t0 : t0) - (s1_reg ? -t1 : t1) - (s2_reg ? -t2 : t2);
        numv_next = (sv1_reg ? -w1 : w1) - (sv2_reg ? -w2 : w2);
        su_next = signed'((ACC_W'(pa00_reg) + (ACC_W'(pa01_reg) << (CW + 1))
                 + (ACC_W'(pa11_reg) << (2*CW)) + (ACC_W'(pa02_reg) << (2*CW + 1))
                 + (ACC_W'(pa12_reg) << (3*CW + 1)) + (ACC_W'(pa22_reg) << (4*CW))) << 2);
        sq_next = signed'((ACC_W'(pb00_reg) + (ACC_W'(pb01_reg) << (CW + 1))
                 + (ACC_W'(pb11_reg) << (2*CW))) << 2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u0h_reg <= coef.q[2*CW-1:CW] * pxm;
            u0l_reg <= coef.q[CW-1:0] * pxm;
            u1h_reg <= coef.c2_mag[2*CW-1:CW] * pym;
            u1l_reg <= coef.c2_mag[CW-1:0] * pym;
            u2h_reg <= coef.c3_mag[2*CW-1:CW] * pzm;
            u2l_reg <= coef.c3_mag[CW-1:0] * pzm;
            v1_reg  <= coef.ny_mag * pzm;
            v2_reg  <= coef.nz_mag * pym;
            s0_reg  <= px[CW-1];
            s1_reg  <= coef.c2_neg ^ py[CW-1];
            s2_reg  <= coef.c3_neg ^ pz[CW-1];
            sv1_reg <= coef.ny_neg ^ pz[CW-1];
            sv2_reg <= coef.nz_neg ^ py[CW-1];

            numu_reg <= numu_next;
            numv_reg <= numv_next;

            umag_reg <= numu_reg[NU_W-1] ? (3*CW)'(-numu_reg) : (3*CW)'(numu_reg);
            vmag_reg <= numv_reg[NV_W-1] ? (2*CW)'(-numv_reg) : (2*CW)'(numv_reg);
            nu3_reg  <= numu_reg[NU_W-1];
            nv3_reg  <= numv_reg[NV_W-1];

            pa00_reg <= umag_reg[CW-1:0] * umag_reg[CW-1:0];
            pa01_reg <= umag_reg[CW-1:0] * umag_reg[2*CW-1:CW];
            pa02_reg <= umag_reg[CW-1:0] * umag_reg[3*CW-1:2*CW];
            pa11_reg <= umag_reg[2*CW-1:CW] * umag_reg[2*CW-1:CW];
            pa12_reg <= umag_reg[2*CW-1:CW] * umag_reg[3*CW-1:2*CW];
            pa22_reg <= umag_reg[3*CW-1:2*CW] * umag_reg[3*CW-1:2*CW];
            pb00_reg <= vmag_reg[CW-1:0] * vmag_reg[CW-1:0];
            pb01_reg <= vmag_reg[CW-1:0] * vmag_reg[2*CW-1:CW];
            pb11_reg <= vmag_reg[2*CW-1:CW] * vmag_reg[2*CW-1:CW];
            nu4_reg  <= nu3_reg;
            nv4_reg  <= nv3_reg;

            su_reg  <= su_next;
            sq_reg  <= sq_next;
            nu5_reg <= nu4_reg;
            nv5_reg <= nv4_reg;
        end
    end

    assign v_out = fv_reg[4];

    // search starts at m = 0: t = den, ws = -den shifted to the top bit
    always_comb
    begin
        init.u.t   = signed'(ACC_W'(coef.den_u));
        init.u.ws  = -signed'(ACC_W'(coef.den_u) << (CW + 1));
        init.u.s   = su_reg;
        init.u.m   = '0;
        init.u.neg = nu5_reg;
        init.v.t   = signed'(ACC_W'(coef.q));
        init.v.ws  = -signed'(ACC_W'(coef.q) << (CW + 1));
        init.v.s   = sq_reg;
        init.v.m   = '0;
        init.v.neg = nv5_reg;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ppp_step.sv
// One stage of the rounded root-ratio search: settles one result bit per lane.
`default_nettype none

module ppp_step (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         v_in,
    input  ppp_pkg::srch_t                    d_in,
    input  wire logic signed [ppp_pkg::ACC_W-1:0] d_u,
    input  wire logic signed [ppp_pkg::ACC_W-1:0] d_v,
    output logic                              v_out,
    output ppp_pkg::srch_t                    d_out
);
    import ppp_pkg::*;

    logic  v_reg;
    srch_t d_reg, d_next;

    // trial bit: (2m'-1)^2 den = t + ws + d; keep it if it stays within 4 num^2
    function automatic lane_t step_lane(input lane_t x, input logic signed [ACC_W-1:0] d);
        lane_t r;
        logic signed [ACC_W-1:0] t, ws, s, tn, wn;
        logic keep;
        t    = x.t;
        ws   = x.ws;
        s    = x.s;
        tn   = t + ws + d;
        keep = (tn <= s);
        wn   = keep ? (ws + (d <<< 1)) : ws;
        r    = x;
        r.t  = keep ? tn : t;
        r.ws = wn >>> 1;
        r.m  = {x.m[CW-2:0], keep};
        return r;
    endfunction

    always_comb
    begin
        d_next.u = step_lane(d_in.u, d_u);
        d_next.v = step_lane(d_in.v, d_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign v_out = v_reg;
    assign d_out = d_reg;

endmodule

`default_nettype wire

FILE: tb/plane_point_projection_tb.sv
// Self-checking testbench for the plane point projection block.
`timescale 1ns / 1ps

module plane_point_projection_tb;
    import ppp_pkg::*;

    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
    } point_t;

    typedef struct {
        logic [CW-1:0] u;
        logic [CW-1:0] v;
        logic          deg;
        logic          sat;
    } coord_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [CW-1:0] ONE   = CW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] S_MIN = HALF;
    localparam logic [CW-1:0] S_MAX = ~HALF;

    logic clk;
    logic rst_n;

    ppp_cfg_if   cfg_if();
    ppp_point_if pt_if();
    ppp_coord_if crd_if();

    plane_point_projection u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_if),
        .point_in  (pt_if),
        .coord_out (crd_if)
    );

    // normal as seen by the block
    logic signed [CW-1:0] nrm_x, nrm_y, nrm_z;

    point_t pending_points[$];
    coord_t expected_coords[$];

    int unsigned mismatches, coords_seen, degen_seen, sat_seen;
    logic pt_taken, crd_taken;
    int   send_gap, recv_wait, long_hold_left;
    bit   sender_idle_on, recv_idle_on, long_hold_req, long_hold_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Round |num|/sqrt(den) to nearest, ties away from zero, and clip.
    function automatic logic [CW-1:0] round_coord(input logic signed [255:0] num,
                                                  input logic [255:0] den,
                                                  inout logic sat);
        logic [255:0] mg, num4, k, lhs;
        logic [63:0]  lo, hi, mid, lim;
        logic         neg;
        neg  = num < 0;
        mg   = neg ? -num : num;
        num4 = (mg * mg) << 2;
        lo   = 0;
        hi   = (64'd1 << (CW - 1)) + 1;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            k   = 256'(2 * mid - 1);
            lhs = k * k * den;
            if (lhs <= num4)
                lo = mid;
            else
                hi = mid - 1;
        end
        lim = neg ? (64'd1 << (CW - 1)) : (64'd1 << (CW - 1)) - 1;
        if (lo > lim)
        begin
            lo  = lim;
            sat = 1'b1;
        end
        return neg ? -lo[CW-1:0] : lo[CW-1:0];
    endfunction

    function automatic coord_t project_point(input point_t p);
        logic signed [255:0] nx, ny, nz, px, py, pz, q, n2, num_u, num_v;
        coord_t c;
        nx = nrm_x; ny = nrm_y; nz = nrm_z;
        px = p.px;  py = p.py;  pz = p.pz;
        c  = '{u: '0, v: '0, deg: 1'b0, sat: 1'b0};
        q  = ny * ny + nz * nz;
        if (q == 0)
        begin
            c.deg = 1'b1;
            return c;
        end
        n2    = q + nx * nx;
        num_u = q * px - nx * (ny * py + nz * pz);
        num_v = ny * pz - nz * py;
        c.u   = round_coord(num_u, q * n2, c.sat);
        c.v   = round_coord(num_v, q, c.sat);
        return c;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        logic [CW-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return S_MIN;
            1: return S_MAX;
            2: return {{16{r[15]}}, r[15:0]};
            3: return {{8{r[23]}}, r[23:0]};
            4: return $urandom_range(0, 1) ? ONE : -ONE;
            default: return r;
        endcase
    endfunction

    // Accept side: requests, results and register writes.
    always @(posedge clk)
    begin
        coord_t got, want;
        pt_taken  <= rst_n && pt_if.valid && pt_if.ready;
        crd_taken <= rst_n && crd_if.valid && crd_if.ready;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.index)
                    REG_NORMAL_X: nrm_x <= cfg_if.data;
                    REG_NORMAL_Y: nrm_y <= cfg_if.data;
                    REG_NORMAL_Z: nrm_z <= cfg_if.data;
                    default: ;
                endcase
            end
            if (pt_if.valid && pt_if.ready)
            begin
                expected_coords.push_back(project_point('{pt_if.point_x, pt_if.point_y,
                                                          pt_if.point_z}));
            end
            if (crd_if.valid && crd_if.ready)
            begin
                got = '{crd_if.coord_u, crd_if.coord_v, crd_if.degenerate, crd_if.saturated};
                coords_seen++;
                if (got.deg) degen_seen++;
                if (got.sat) sat_seen++;
                if (expected_coords.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result u=%h v=%h", got.u, got.v);
                end
                else
                begin
                    want = expected_coords.pop_front();
                    if (got.u !== want.u || got.v !== want.v || got.deg !== want.deg
                        || got.sat !== want.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch n=(%h %h %h): exp u=%h v=%h d=%b s=%b, got u=%h v=%h d=%b s=%b",
                                     nrm_x, nrm_y, nrm_z, want.u, want.v, want.deg, want.sat,
                                     got.u, got.v, got.deg, got.sat);
                    end
                end
            end
        end
    end

    // Point driver.
    always @(negedge clk)
    begin
        point_t p;
        if (rst_n && (!pt_if.valid || pt_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                pt_if.valid <= 1'b0;
            end
            else if (pending_points.size() > 0)
            begin
                p = pending_points.pop_front();
                pt_if.valid   <= 1'b1;
                pt_if.point_x <= p.px;
                pt_if.point_y <= p.py;
                pt_if.point_z <= p.pz;
                send_gap = (sender_idle_on && $urandom_range(0, 2) == 0) ?
                           $urandom_range(0, 15) : 0;
            end
            else
                pt_if.valid <= 1'b0;
        end
    end

    // Result receiver, with one long hold-off on request.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                long_hold_left = 300;
            end
            if (crd_taken)
                recv_wait = (recv_idle_on && $urandom_range(0, 2) == 0) ?
                            $urandom_range(0, 15) : 0;
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                crd_if.ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                crd_if.ready <= 1'b0;
            end
            else
                crd_if.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_normal(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z);
        write_reg(REG_NORMAL_X, x);
        write_reg(REG_NORMAL_Y, y);
        write_reg(REG_NORMAL_Z, z);
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || pt_if.valid || expected_coords.size() > 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic add_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [CW-1:0] z);
        pending_points.push_back('{x, y, z});
    endtask

    task automatic add_random(input int n);
        repeat (n) add_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        pt_if.valid   = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.point_z = '0;
        crd_if.ready  = 1'b0;
        nrm_x = '0;
        nrm_y = '0;
        nrm_z = ONE;
        mismatches = 0; coords_seen = 0; degen_seen = 0; sat_seen = 0;
        send_gap = 0; recv_wait = 0; long_hold_left = 0;
        sender_idle_on = 1'b1; recv_idle_on = 1'b1;
        long_hold_req = 1'b0; long_hold_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset normal: extremes and simple points.
        add_point('0, '0, '0);
        add_point(S_MAX, S_MAX, S_MAX);
        add_point(S_MIN, S_MIN, S_MIN);
        add_point(S_MAX, S_MIN, S_MAX);
        add_point(S_MIN, S_MAX, S_MIN);
        add_point(ONE, ONE, ONE);
        add_point(-ONE, -ONE, -ONE);
        add_point(32'd1, -32'd1, 32'd1);
        add_point('1, 32'd1, '1);
        drain();

        // Huge normals push the u coordinate out of range.
        set_normal(S_MAX, 32'd1, '0);
        add_point(S_MAX, '0, S_MIN);
        add_point(S_MIN, S_MAX, '0);
        add_point(32'd3, 32'd5, 32'd7);
        add_random(100);
        drain();

        // Normal parallel to x, then zero normal.
        set_normal(ONE, '0, '0);
        add_point(ONE, ONE, ONE);
        add_random(60);
        drain();
        write_reg(REG_NORMAL_X, '0);
        add_random(40);
        drain();

        // Ignored index, normals at the extremes.
        set_normal(S_MIN, S_MAX, S_MIN);
        write_reg(REG_UNUSED, 32'h1234_5678);
        add_point(S_MIN, S_MIN, S_MIN);
        add_point(S_MAX, S_MAX, S_MAX);
        add_random(150);
        drain();
        set_normal(S_MAX, S_MIN, S_MAX);
        add_random(150);
        drain();

        // Long receiver hold-off with a back-to-back sender.
        sender_idle_on = 1'b0;
        recv_idle_on   = 1'b0;
        set_normal(ONE, -ONE, ONE << 1);
        long_hold_req = 1'b1;
        add_random(200);
        drain();
        sender_idle_on = 1'b1;
        recv_idle_on   = 1'b1;

        // Random normals, mostly small, some full range.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 3 == 0)
                set_normal($urandom, $urandom, $urandom);
            else if (ph == 4)
                set_normal($urandom, '0, '0);
            else
                set_normal(rand_coord(), rand_coord(), rand_coord());
            sender_idle_on = ph[0];
            recv_idle_on   = ph[1];
            add_random(100);
            drain();
        end

        if (expected_coords.size() > 0)
            mismatches += expected_coords.size();
        $display("covered %0d points, %0d degenerate, %0d clipped, over 15 normal settings",
                 coords_seen, degen_seen, sat_seen);
        if (mismatches == 0)
            $display("plane_point_projection_tb: clean");
        else
            $display("plane_point_projection_tb: errors");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout waiting for results");
        $display("plane_point_projection_tb: errors");
        $finish;
    end

endmodule
